>>> hdl/rbgd_pkg.sv
// ----------------------------------------------------------------------------
// rbgd_pkg
// Shared types and constants of the run-length RBG323 frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbgd_pkg;

  // Field widths
  localparam int CFG_W    = 13;
  localparam int STRIDE_W = 16;
  localparam int ADDR_W   = 28;
  localparam int POS_W    = 12;
  localparam int BYTE_W   = 8;

  typedef logic [CFG_W-1:0]    dim_t;
  typedef logic [STRIDE_W-1:0] stride_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [BYTE_W-1:0]   byte_t;

  // Lower bounds of the effective frame size
  localparam dim_t MIN_WIDTH  = 13'd8;
  localparam dim_t MIN_HEIGHT = 13'd1;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LINE_STRIDE  = 2'd2;

  // Opcode boundaries
  localparam byte_t OP_RUN_MIN = 8'h01;
  localparam byte_t OP_RUN_MAX = 8'hBF;
  localparam byte_t OP_LIT_BAD = 8'hC0;
  localparam byte_t OP_LIT_MIN = 8'hC1;
  localparam byte_t OP_LIT_MAX = 8'hFF;

  // Parser phase
  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_VALUE,
    PH_LITERAL,
    PH_SKIP
  } phase_t;

  // Command handed from the parser to the painter
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_ERR,
    CMD_RUN,
    CMD_LIT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    byte_t     count;
    byte_t     pixel;
    logic      last;
  } cmd_t;

  // Effective frame geometry
  typedef struct packed {
    dim_t    width;
    dim_t    height;
    stride_t stride;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic  kind;
    addr_t seg_addr;
    pos_t  seg_x;
    pos_t  seg_y;
    byte_t seg_len;
    byte_t pixel;
    logic  frame_full;
    logic  run_last;
  } res_t;

  // RBG323 to BGR8
  function automatic byte_t to_bgr8(input byte_t b);
    to_bgr8 = {b[4:0], b[7:5]};
  endfunction

endpackage

`default_nettype wire

>>> hdl/rle8_rbg323_frame_decoder.sv
// ----------------------------------------------------------------------------
// rle8_rbg323_frame_decoder
// Run-length decoder turning RBG323 packets into BGR8 row-fill segments.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | in_byte, packet_end
//  out      | out_valid / out_stall| kind, seg_addr, seg_x, seg_y, seg_len,
//           |                      | pixel, frame_full, run_last
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  The parser takes one byte per cycle into a two-entry command queue.
//  The painter emits one segment per cycle unless the output stalls; a run
//  spanning k rows is held as one segment per row. The queue stalls input
//  when full. Results pass queue slot, active command and output registers.
//  Reset is synchronous and clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rle8_rbg323_frame_decoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_byte,
  input  wire         packet_end,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        kind,
  output logic [27:0] seg_addr,
  output logic [11:0] seg_x,
  output logic [11:0] seg_y,
  output logic [7:0]  seg_len,
  output logic [7:0]  pixel,
  output logic        frame_full,
  output logic        run_last
);

  localparam int CFG_MAX = (1 << rbgd_pkg::CFG_W) - 1;
  localparam int W_CAP   = (MAX_WIDTH  > CFG_MAX) ? CFG_MAX : MAX_WIDTH;
  localparam int H_CAP   = (MAX_HEIGHT > CFG_MAX) ? CFG_MAX : MAX_HEIGHT;
  localparam rbgd_pkg::dim_t W_HI  = rbgd_pkg::dim_t'(W_CAP);
  localparam rbgd_pkg::dim_t H_HI  = rbgd_pkg::dim_t'(H_CAP);
  localparam rbgd_pkg::dim_t W_RST = rbgd_pkg::dim_t'((640 > W_CAP) ? W_CAP : 640);
  localparam rbgd_pkg::dim_t H_RST = rbgd_pkg::dim_t'((480 > H_CAP) ? H_CAP : 480);

  rbgd_pkg::cfg_t  cfg;
  rbgd_pkg::dim_t  w_sat;
  rbgd_pkg::dim_t  h_sat;
  logic            q_push;
  rbgd_pkg::cmd_t  push_cmd;
  logic            q_full;
  logic            q_valid;
  rbgd_pkg::cmd_t  head_cmd;
  logic            q_pop;
  rbgd_pkg::res_t  res;

  // Saturate frame size as it is written
  always_comb begin
    w_sat = cfg_data[12:0];
    if (w_sat < rbgd_pkg::MIN_WIDTH) w_sat = rbgd_pkg::MIN_WIDTH;
    else if (w_sat > W_HI) w_sat = W_HI;
    h_sat = cfg_data[12:0];
    if (h_sat < rbgd_pkg::MIN_HEIGHT) h_sat = rbgd_pkg::MIN_HEIGHT;
    else if (h_sat > H_HI) h_sat = H_HI;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= W_RST;
      cfg.height <= H_RST;
      cfg.stride <= 16'd640;
    end else if (cfg_we) begin
      case (cfg_index)
        rbgd_pkg::REG_FRAME_WIDTH:  cfg.width  <= w_sat;
        rbgd_pkg::REG_FRAME_HEIGHT: cfg.height <= h_sat;
        rbgd_pkg::REG_LINE_STRIDE:  cfg.stride <= cfg_data;
        default: ;
      endcase
    end
  end

  rbgd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .packet_end (packet_end),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  rbgd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_cmd   (head_cmd),
    .pop       (q_pop)
  );

  rbgd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Unpack the result word
  assign kind       = res.kind;
  assign seg_addr   = res.seg_addr;
  assign seg_x      = res.seg_x;
  assign seg_y      = res.seg_y;
  assign seg_len    = res.seg_len;
  assign pixel      = res.pixel;
  assign frame_full = res.frame_full;
  assign run_last   = res.run_last;

  // Checks
  a_fill_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> seg_len != 8'd0)
    else $error("fill segment with zero length");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> run_last && seg_len == 8'd0 && !frame_full)
    else $error("error result not a lone zeroed word");

  a_full_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_full |-> run_last)
    else $error("frame full segment not last of its byte");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

>>> hdl/rbgd_front.sv
// ----------------------------------------------------------------------------
// rbgd_front
// Packet parser: classifies each byte and pushes paint commands to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbgd_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  rbgd_pkg::byte_t in_byte,
  input  wire                  packet_end,
  input  wire                  q_full,
  output logic                 q_push,
  output rbgd_pkg::cmd_t       q_cmd
);

  rbgd_pkg::phase_t phase, phase_next;
  rbgd_pkg::byte_t  count, count_next;
  logic             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Phase and pending count
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= rbgd_pkg::PH_OPCODE;
      count <= '0;
    end else if (accept) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  // Classify the byte
  always_comb begin
    phase_next  = phase;
    count_next  = count;
    q_cmd.kind  = rbgd_pkg::CMD_NOP;
    q_cmd.count = count;
    q_cmd.pixel = rbgd_pkg::to_bgr8(in_byte);
    q_cmd.last  = packet_end;
    case (phase)
      rbgd_pkg::PH_OPCODE: begin
        if (!packet_end) begin
          case (in_byte) inside
            [rbgd_pkg::OP_RUN_MIN:rbgd_pkg::OP_RUN_MAX]: begin
              count_next = in_byte;
              phase_next = rbgd_pkg::PH_VALUE;
            end
            [rbgd_pkg::OP_LIT_MIN:rbgd_pkg::OP_LIT_MAX]: begin
              count_next = in_byte - rbgd_pkg::OP_LIT_BAD;
              phase_next = rbgd_pkg::PH_LITERAL;
            end
            default: begin
              q_cmd.kind = rbgd_pkg::CMD_ERR;
              phase_next = rbgd_pkg::PH_SKIP;
            end
          endcase
        end
      end
      rbgd_pkg::PH_VALUE: begin
        q_cmd.kind = rbgd_pkg::CMD_RUN;
        count_next = '0;
        phase_next = rbgd_pkg::PH_OPCODE;
      end
      rbgd_pkg::PH_LITERAL: begin
        q_cmd.kind  = rbgd_pkg::CMD_LIT;
        q_cmd.count = 8'd1;
        count_next  = count - 8'd1;
        if (count == 8'd1) phase_next = rbgd_pkg::PH_OPCODE;
      end
      default: begin
        q_cmd.kind = rbgd_pkg::CMD_NOP;
      end
    endcase
    // Return to the opcode phase at packet end
    if (packet_end) begin
      phase_next = rbgd_pkg::PH_OPCODE;
      count_next = '0;
    end
  end

  // Drop idle bytes that do not close the packet
  assign q_push = accept && ((q_cmd.kind != rbgd_pkg::CMD_NOP) || packet_end);

endmodule

`default_nettype wire

>>> hdl/rbgd_queue.sv
// ----------------------------------------------------------------------------
// rbgd_queue
// Two-entry command queue between the parser and the painter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbgd_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wire  rbgd_pkg::cmd_t push_cmd,
  output logic                 full,
  output logic                 pop_valid,
  output rbgd_pkg::cmd_t       pop_cmd,
  input  wire                  pop
);

  rbgd_pkg::cmd_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           do_push;
  logic           do_pop;

  assign full      = (fill == 2'd2);
  assign pop_valid = (fill != 2'd0);
  assign pop_cmd   = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/rbgd_back.sv
// ----------------------------------------------------------------------------
// rbgd_back
// Painter: walks the frame cursor; emits one row segment per unstalled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbgd_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire  rbgd_pkg::cfg_t cfg,
  input  wire                  q_valid,
  input  wire  rbgd_pkg::cmd_t q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output rbgd_pkg::res_t       res
);

  // Active command
  logic             act_valid;
  rbgd_pkg::cmd_t   act;
  rbgd_pkg::byte_t  act_cnt;

  // Frame cursor
  rbgd_pkg::dim_t   col;
  rbgd_pkg::pos_t   row;
  rbgd_pkg::addr_t  row_base;
  logic             full_skip;

  logic             out_free;
  logic             step;
  rbgd_pkg::dim_t   rem;
  rbgd_pkg::pos_t   row_inc;
  logic             eor;
  rbgd_pkg::byte_t  seg_n;
  logic             fills;
  logic             is_err;
  logic             hit_full;
  logic             more;
  logic             emit;
  logic             act_done;

  // Segment arithmetic
  always_comb begin
    out_free = !out_valid || !out_stall;
    step     = act_valid && out_free;
    rem      = cfg.width - col;
    row_inc  = row + 12'd1;
    eor      = ({5'd0, act_cnt} >= rem);
    seg_n    = eor ? rem[7:0] : act_cnt;
    fills    = !full_skip && ((act.kind == rbgd_pkg::CMD_RUN) ||
                              (act.kind == rbgd_pkg::CMD_LIT)) &&
               (col < cfg.width) && (act_cnt != 8'd0);
    is_err   = !full_skip && (act.kind == rbgd_pkg::CMD_ERR);
    hit_full = fills && eor &&
               (({1'b0, row_inc} >= cfg.height) || (row_inc == '0));
    more     = fills && eor && (act_cnt != rem[7:0]) && !hit_full;
    emit     = step && (fills || is_err);
    act_done = step && !more;
    q_pop    = q_valid && (!act_valid || act_done);
  end

  // Load and retire commands
  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
    end else if (q_pop) begin
      act_valid <= 1'b1;
    end else if (act_done) begin
      act_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      act     <= q_cmd;
      act_cnt <= q_cmd.count;
    end else if (step && fills) begin
      act_cnt <= act_cnt - seg_n;
    end
  end

  // Move the cursor; clear it at packet end
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      row_base  <= '0;
      full_skip <= 1'b0;
    end else if (act_done && act.last) begin
      col       <= '0;
      row       <= '0;
      row_base  <= '0;
      full_skip <= 1'b0;
    end else if (step && fills) begin
      if (eor) begin
        col      <= '0;
        row      <= row_inc;
        row_base <= row_base + {12'd0, cfg.stride};
        if (hit_full) full_skip <= 1'b1;
      end else begin
        col <= col + {5'd0, act_cnt};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.kind       <= is_err;
      res.seg_addr   <= is_err ? '0 : row_base + {15'd0, col};
      res.seg_x      <= is_err ? '0 : col[11:0];
      res.seg_y      <= is_err ? '0 : row;
      res.seg_len    <= is_err ? '0 : seg_n;
      res.pixel      <= is_err ? '0 : act.pixel;
      res.frame_full <= hit_full;
      res.run_last   <= act_done;
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_rle8_rbg323_frame_decoder.sv
// ----------------------------------------------------------------------------
// tb_rle8_rbg323_frame_decoder
// Self-checking bench for the run-length RBG323 frame decoder. A segment
// predictor in a small scoreboard class tracks the cursor, the row base and
// the parser phase. It queues the segments that each accepted byte should
// produce, and every segment that leaves the block is checked against them
// in order. Stimulus is a short directed set, then random packets built
// mostly from well-formed opcode sequences. Both sides idle in random bursts,
// and the frame geometry changes between packets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rle8_rbg323_frame_decoder;
  import rbgd_pkg::*;

  localparam int FRAME_MAX_W  = 4096;
  localparam int FRAME_MAX_H  = 4096;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int TARGET_WORDS = 420;
  localparam int CALM_WORDS   = 360;

  // Opcode zero has no name in the package
  localparam byte_t OP_ZERO = 8'h00;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_FRAME_WIDTH;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        packet_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [27:0] seg_addr;
  logic [11:0] seg_x;
  logic [11:0] seg_y;
  logic [7:0]  seg_len;
  logic [7:0]  pixel;
  logic        frame_full;
  logic        run_last;

  // Run controls shared by the driving processes
  bit          calm = 1'b0;
  bit          tx_quiet = 1'b0;
  int          hold_ask = 0;
  int          hold_seen = 0;
  int          stall_left = 0;
  bit          rx_quiet = 1'b0;
  int          quiet_cycles = 0;
  int          words_used = 0;
  byte_t       pkt[$];

  // --------------------------------------------------------------------------
  // Segment predictor and the segments still owed by the block
  // --------------------------------------------------------------------------
  class seg_scoreboard;
    dim_t        width_reg;
    dim_t        height_reg;
    stride_t     stride_reg;
    phase_t      phase_now;
    int          pending;
    int          col;
    int          row;
    addr_t       row_base;
    int          step_segs;
    int unsigned fails;
    res_t        due_segs[$];

    function new();
      width_reg  = 13'd640;
      height_reg = 13'd480;
      stride_reg = 16'd640;
      fails      = 0;
      rewind();
    endfunction

    // Return the cursor to the top-left corner of the frame
    function void rewind();
      phase_now = PH_OPCODE;
      pending   = 0;
      col       = 0;
      row       = 0;
      row_base  = '0;
    endfunction

    function void take_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_FRAME_WIDTH:  width_reg  = data[CFG_W-1:0];
        REG_FRAME_HEIGHT: height_reg = data[CFG_W-1:0];
        REG_LINE_STRIDE:  stride_reg = data;
        default: ;
      endcase
    endfunction

    // Paint up to len pixels at the cursor; return pixels painted
    function int paint(int len, byte_t pix);
      int   w;
      int   h;
      int   n;
      res_t seg;
      w = int'(width_reg);
      h = int'(height_reg);
      if (w < int'(MIN_WIDTH)) w = int'(MIN_WIDTH);
      if (w > FRAME_MAX_W) w = FRAME_MAX_W;
      if (h < int'(MIN_HEIGHT)) h = int'(MIN_HEIGHT);
      if (h > FRAME_MAX_H) h = FRAME_MAX_H;
      if (col >= w || len == 0) return 0;
      n = w - col;
      if (len < n) n = len;
      seg          = '0;
      seg.seg_addr = row_base + addr_t'(col);
      seg.seg_x    = pos_t'(col);
      seg.seg_y    = pos_t'(row);
      seg.seg_len  = byte_t'(n);
      seg.pixel    = pix;
      col += n;
      // Advance to the next row at the right edge
      if (col >= w) begin
        row      = (row + 1) % (1 << POS_W);
        row_base = row_base + addr_t'(stride_reg);
        col      = 0;
        if (row >= h || row == 0) begin
          seg.frame_full = 1'b1;
          phase_now      = PH_SKIP;
        end
      end
      due_segs.push_back(seg);
      step_segs++;
      return n;
    endfunction

    // Queue the segments of one accepted word; return 0 if it was ignored
    function bit note_byte(byte_t b, bit last);
      res_t  seg;
      byte_t pix;
      int    left;
      int    n;
      bit    took;
      took      = 1'b1;
      step_segs = 0;
      pix       = (b << 3) | (b >> 5);
      case (phase_now)
        PH_OPCODE: begin
          if (last) begin
            took = 1'b0;
          end else if (b >= OP_RUN_MIN && b <= OP_RUN_MAX) begin
            pending   = int'(b);
            phase_now = PH_VALUE;
          end else if (b >= OP_LIT_MIN) begin
            pending   = int'(b) - int'(OP_LIT_BAD);
            phase_now = PH_LITERAL;
          end else begin
            seg      = '0;
            seg.kind = 1'b1;
            due_segs.push_back(seg);
            step_segs = 1;
            phase_now = PH_SKIP;
          end
        end
        PH_VALUE: begin
          left      = pending;
          phase_now = PH_OPCODE;
          while (left > 0 && phase_now != PH_SKIP) begin
            n    = paint(left, pix);
            left = (n == 0) ? 0 : left - n;
          end
          pending = 0;
        end
        PH_LITERAL: begin
          void'(paint(1, pix));
          if (phase_now != PH_SKIP) begin
            pending = (pending - 1) & 8'hFF;
            if (pending == 0) phase_now = PH_OPCODE;
          end
        end
        default: took = 1'b0;
      endcase
      // Mark the last segment of this word
      if (step_segs > 0) begin
        seg          = due_segs.pop_back();
        seg.run_last = 1'b1;
        due_segs.push_back(seg);
      end
      if (last) rewind();
      return took;
    endfunction

    function void check_seg(res_t got);
      res_t want;
      if (due_segs.size() == 0) begin
        $error("segment with none expected: x %0d y %0d len %0d",
               got.seg_x, got.seg_y, got.seg_len);
        fails++;
      end else begin
        want = due_segs.pop_front();
        if (got.kind != want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got.kind);
          fails++;
        end
        if (got.seg_addr != want.seg_addr) begin
          $error("seg_addr: expected 0x%07h, got 0x%07h", want.seg_addr, got.seg_addr);
          fails++;
        end
        if (got.seg_x != want.seg_x) begin
          $error("seg_x: expected %0d, got %0d", want.seg_x, got.seg_x);
          fails++;
        end
        if (got.seg_y != want.seg_y) begin
          $error("seg_y: expected %0d, got %0d", want.seg_y, got.seg_y);
          fails++;
        end
        if (got.seg_len != want.seg_len) begin
          $error("seg_len: expected %0d, got %0d", want.seg_len, got.seg_len);
          fails++;
        end
        if (got.pixel != want.pixel) begin
          $error("pixel: expected 0x%02h, got 0x%02h", want.pixel, got.pixel);
          fails++;
        end
        if (got.frame_full != want.frame_full) begin
          $error("frame_full: expected %0d, got %0d", want.frame_full, got.frame_full);
          fails++;
        end
        if (got.run_last != want.run_last) begin
          $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
          fails++;
        end
      end
    endfunction
  endclass

  seg_scoreboard sb = new();

  rle8_rbg323_frame_decoder #(
    .MAX_WIDTH (FRAME_MAX_W),
    .MAX_HEIGHT(FRAME_MAX_H)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .packet_end(packet_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .seg_addr  (seg_addr),
    .seg_x     (seg_x),
    .seg_y     (seg_y),
    .seg_len   (seg_len),
    .pixel     (pixel),
    .frame_full(frame_full),
    .run_last  (run_last)
  );

  always #2 clk = ~clk;

  // Check every segment word taken from the block
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_seg({kind, seg_addr, seg_x, seg_y, seg_len, pixel, frame_full, run_last});
    end
  end

  // Receiver stalls: random bursts, quiet stretches, one long hold-off on request
  always @(posedge clk) begin
    if ($urandom_range(0, 149) == 0) rx_quiet <= !rx_quiet;
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (hold_ask != hold_seen) begin
      hold_seen  <= hold_ask;
      out_stall  <= 1'b1;
      stall_left <= HOLD_CYCLES - 1;
    end else if (!calm && !rx_quiet && $urandom_range(0, 6) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_rle8_rbg323_frame_decoder NOT OK");
      $finish;
    end
  end

  // Offer one word and hold it until the block takes it
  task automatic send_word(input byte_t b, input bit last);
    if ($urandom_range(0, 59) == 0) tx_quiet = !tx_quiet;
    if (!calm && !tx_quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    packet_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    void'(sb.note_byte(b, last));
    words_used++;
  endtask

  task automatic send_pkt(input bit close);
    foreach (pkt[i]) send_word(pkt[i], close && (i == pkt.size() - 1));
  endtask

  // Stop offering and wait for every owed segment plus the pipeline tail
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_segs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.take_reg(idx, data);
  endtask

  task automatic set_frame(input logic [15:0] w, input logic [15:0] h, input logic [15:0] s);
    drain();
    load_reg(REG_FRAME_WIDTH, w);
    load_reg(REG_FRAME_HEIGHT, h);
    load_reg(REG_LINE_STRIDE, s);
    cfg_we <= 1'b0;
  endtask

  // Build a random packet: mostly well-formed opcodes, some noise and bad endings
  task automatic make_packet();
    int pick;
    int cnt;
    pkt = {};
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 191) : $urandom_range(1, 24);
        pkt.push_back(byte_t'(cnt));
        pkt.push_back(byte_t'($urandom));
      end else if (pick < 85) begin
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 6);
        pkt.push_back(byte_t'(int'(OP_LIT_BAD) + cnt));
        repeat (cnt) pkt.push_back(byte_t'($urandom));
      end else if (pick < 93) begin
        pkt.push_back($urandom_range(0, 1) ? OP_LIT_BAD : OP_ZERO);
        repeat ($urandom_range(0, 3)) pkt.push_back(byte_t'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) pkt.push_back(byte_t'($urandom));
      end
    end
    // Cut the packet short, or end it on a stray byte
    pick = $urandom_range(0, 7);
    if (pick == 0 && pkt.size() > 1) begin
      repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
    end else if (pick == 1) begin
      pkt.push_back(byte_t'($urandom));
    end
  endtask

  initial begin
    int n_pkts;
    int w;
    n_pkts = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: shortest and longest runs, literals, opcode on the last word
    pkt = {OP_RUN_MIN, 8'h00, OP_RUN_MAX, 8'hFF, OP_LIT_MIN, 8'hA5, 8'h05};
    send_pkt(1'b1);
    // Literal cut by the end of the packet
    pkt = {OP_LIT_MAX, 8'h80, 8'h7F};
    send_pkt(1'b1);
    // Error opcodes, and error opcodes on the last word
    pkt = {OP_ZERO, 8'h11, 8'h22};
    send_pkt(1'b1);
    pkt = {OP_LIT_BAD};
    send_pkt(1'b1);
    pkt = {OP_ZERO};
    send_pkt(1'b1);

    // Fill a tiny frame, then bytes after the fill are dropped
    set_frame(16'd8, 16'd2, 16'd8);
    pkt = {8'h20, 8'h55, 8'h03, 8'h44, 8'h01};
    send_pkt(1'b1);

    // Narrow the frame mid-packet, then widen it with a new stride
    set_frame(16'd16, 16'd4, 16'd100);
    pkt = {8'h0A, 8'h11};
    send_pkt(1'b0);
    set_frame(16'd8, 16'd4, 16'd200);
    pkt = {8'h02, 8'h22, 8'hC2, 8'h01, 8'h02};
    send_pkt(1'b0);
    set_frame(16'd16, 16'd4, 16'd300);
    pkt = {8'h0A, 8'h33};
    send_pkt(1'b1);

    // Random packets with geometry changes between them
    while (words_used < TARGET_WORDS) begin
      if (n_pkts == 8) begin
        set_frame(16'd24, 16'd40, 16'd24);
        hold_ask++;
      end else if (n_pkts % 6 == 5) begin
        case ($urandom_range(0, 7))
          0: set_frame(16'd8, 16'd1, 16'd8);
          1: set_frame(16'd4096, 16'd4096, 16'hFFFF);
          2: set_frame(16'd0, 16'd0, 16'd0);
          3: set_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
          default: begin
            w = $urandom_range(8, 48);
            set_frame(16'(w), 16'($urandom_range(1, 8)),
                      $urandom_range(0, 1) ? 16'(w) : 16'($urandom_range(8, 65535)));
          end
        endcase
      end
      if (words_used >= CALM_WORDS) calm = 1'b1;
      make_packet();
      send_pkt(1'b1);
      n_pkts++;
    end

    drain();
    if (sb.fails == 0) begin
      $display("tb_rle8_rbg323_frame_decoder OK");
    end else begin
      $display("tb_rle8_rbg323_frame_decoder NOT OK");
    end
    $finish;
  end

endmodule
